// File: rtl/cbm_pkg.sv
// Shared types and constants of the caller blocklist matcher.
package cbm_pkg;

    localparam int TableEntries = 32;
    localparam int SlotW = $clog2(TableEntries);
    localparam int MaxDigits = 16;
    localparam int CountW = 5;

    localparam logic [2:0] KIND_ADD = 3'd0;
    localparam logic [2:0] KIND_DELETE = 3'd1;
    localparam logic [2:0] KIND_CHECK = 3'd2;
    localparam logic [2:0] KIND_FIND_ID = 3'd3;
    localparam logic [2:0] KIND_FIND_NUM = 3'd4;

    localparam logic [1:0] TYPE_CONTACT = 2'd0;
    localparam logic [1:0] TYPE_AREA = 2'd1;
    localparam logic [1:0] TYPE_PREFIX = 2'd2;
    localparam logic [1:0] TYPE_NUMBER = 2'd3;

    localparam logic [2:0] ST_OK = 3'd0;
    localparam logic [2:0] ST_INVALID = 3'd1;
    localparam logic [2:0] ST_DUPLICATE = 3'd2;
    localparam logic [2:0] ST_FULL = 3'd3;
    localparam logic [2:0] ST_NOT_FOUND = 3'd4;

    // Controller to datapath
    typedef struct packed {
        logic load;      // capture the input item
        logic scan_rst;  // reset scan index and search flags
        logic scan_step; // evaluate current slot, advance index
        logic commit;    // apply table change and build result
    } cbm_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic scan_last; // current slot is the last one
        logic hit;       // current slot ends the search
    } cbm_stat_t;

    // Mask of the first n digits, top nibble first
    function automatic logic [63:0] digit_mask(input logic [CountW-1:0] n);
        logic [63:0] m;
        m = '0;
        for (int k = 0; k < MaxDigits; k++) begin
            if (k < int'(n)) begin
                m[63-4*k -: 4] = 4'hf;
            end
        end
        return m;
    endfunction

endpackage

// File: rtl/caller_blocklist_matcher_core.sv
// Top level of the caller blocklist matcher.
// Holds 32 blocked entries (contact id, area code, prefix or full number in BCD) and
// serves one operation at a time: add, delete, check caller, find by id, find by number.
// The item is captured at the accepting edge; its result follows a scan of up to 32
// slots, one per cycle through a single compare unit (a check or find stops at the first
// matching slot, an add at the first duplicate), and then the commit state. The result
// then waits for out_ready, and the next item is taken in the cycle after the result
// leaves, so a new item is never accepted while one is still in progress.
// list_version counts table changes modulo 16.
module caller_blocklist_matcher_core (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [2:0]         kind,
    input  logic [1:0]         entry_type,
    input  logic signed [31:0] contact_id,
    input  logic [63:0]        number_digits,
    input  logic [4:0]         digit_count,
    input  logic [4:0]         entry_slot,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [2:0]         status,
    output logic               blocked,
    output logic [4:0]         found_slot,
    output logic [3:0]         list_version
);

    cbm_pkg::cbm_cmd_t  cmd;
    cbm_pkg::cbm_stat_t stat;

    cbm_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    cbm_datapath u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .stat          (stat),
        .kind          (kind),
        .entry_type    (entry_type),
        .contact_id    (contact_id),
        .number_digits (number_digits),
        .digit_count   (digit_count),
        .entry_slot    (entry_slot),
        .status        (status),
        .blocked       (blocked),
        .found_slot    (found_slot),
        .list_version  (list_version)
    );

endmodule

// File: rtl/cbm_ctrl.sv
// Sequencing controller of the caller blocklist matcher.
module cbm_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    output logic               out_valid,
    input  logic               out_ready,
    input  cbm_pkg::cbm_stat_t stat,
    output cbm_pkg::cbm_cmd_t  cmd
);

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_SCAN   = 4'b0010,
        S_COMMIT = 4'b0100,
        S_OUT    = 4'b1000
    } state_t;

    state_t state_reg, state_next;

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = (state_reg == S_OUT);

    // Sequence: load, scan the table, commit, present result
    always_comb
    begin
        state_next = state_reg;
        cmd = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid) begin
                    cmd.load = 1'b1;
                    cmd.scan_rst = 1'b1;
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                cmd.scan_step = 1'b1;
                if (stat.hit || stat.scan_last) begin
                    state_next = S_COMMIT;
                end
            end
            S_COMMIT:
            begin
                cmd.commit = 1'b1;
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (out_ready) begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    a_onehot: assert property (@(posedge clk) disable iff (!rst_n) $onehot(state_reg))
        else $error("state not one-hot");
    a_commit_once: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |=> out_valid) else $error("commit not followed by result");
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid) else $error("result dropped");

endmodule

// File: rtl/cbm_datapath.sv
// Table storage, slot scan and result registers of the caller blocklist matcher.
module cbm_datapath (
    input  logic                      clk,
    input  logic                      rst_n,
    input  cbm_pkg::cbm_cmd_t         cmd,
    output cbm_pkg::cbm_stat_t        stat,
    input  logic [2:0]                kind,
    input  logic [1:0]                entry_type,
    input  logic signed [31:0]        contact_id,
    input  logic [63:0]               number_digits,
    input  logic [4:0]                digit_count,
    input  logic [4:0]                entry_slot,
    output logic [2:0]                status,
    output logic                      blocked,
    output logic [4:0]                found_slot,
    output logic [3:0]                list_version
);

    localparam int SW = cbm_pkg::SlotW;
    localparam int CW = cbm_pkg::CountW;

    // Table storage
    logic [cbm_pkg::TableEntries-1:0] valid_reg;
    logic [1:0]  type_mem   [cbm_pkg::TableEntries];
    logic [31:0] contact_mem[cbm_pkg::TableEntries];
    logic [63:0] digits_mem [cbm_pkg::TableEntries];
    logic [CW-1:0] length_mem[cbm_pkg::TableEntries];

    // Captured item
    logic [2:0]    kind_reg;
    logic [1:0]    type_reg;
    logic [31:0]   cid_reg;
    logic [63:0]   dig_reg;
    logic [CW-1:0] len_reg;
    logic [4:0]    slot_reg;
    // Caller digits after dropping a leading 1
    logic [63:0]   cdig_reg;
    logic [CW-1:0] clen_reg;

    logic [SW-1:0] idx_reg;
    logic          hit_reg;
    logic [SW-1:0] hit_idx_reg;
    logic          free_reg;
    logic [SW-1:0] free_idx_reg;
    logic [3:0]    ver_reg;
    logic [2:0]    status_reg;
    logic          blocked_reg;
    logic [4:0]    found_reg;

    // Clamp and mask the incoming digits
    logic [CW-1:0] in_len;
    logic [63:0]   in_dig;
    always_comb
    begin
        in_len = (digit_count > CW'(cbm_pkg::MaxDigits)) ? CW'(cbm_pkg::MaxDigits) : digit_count;
        in_dig = number_digits & cbm_pkg::digit_mask(in_len);
    end

    // Current slot read
    logic          s_valid;
    logic [1:0]    s_type;
    logic [31:0]   s_cid;
    logic [63:0]   s_dig;
    logic [CW-1:0] s_len;
    logic [63:0]   t_dig;
    logic [CW-1:0] t_len;
    logic          exact_eq;
    logic          pfx_hit;
    logic          num_hit;
    logic          slot_hit;
    logic          add_ok;

    assign add_ok = (len_reg != '0) && !(type_reg == cbm_pkg::TYPE_CONTACT && cid_reg == '0);

    always_comb
    begin
        s_valid = valid_reg[idx_reg];
        s_type  = type_mem[idx_reg];
        s_cid   = contact_mem[idx_reg];
        s_dig   = digits_mem[idx_reg];
        s_len   = length_mem[idx_reg];
        // drop one leading 1 from the stored entry
        if (s_len != '0 && s_dig[63:60] == 4'd1) begin
            t_dig = {s_dig[59:0], 4'd0};
            t_len = s_len - CW'(1);
        end else begin
            t_dig = s_dig;
            t_len = s_len;
        end
        exact_eq = (s_len == len_reg) && (s_dig == dig_reg);
        pfx_hit  = (clen_reg >= t_len) &&
                   (((cdig_reg ^ t_dig) & cbm_pkg::digit_mask(t_len)) == '0);
        num_hit  = (clen_reg == t_len) &&
                   (((cdig_reg ^ t_dig) & cbm_pkg::digit_mask(t_len)) == '0);
        slot_hit = 1'b0;
        case (kind_reg)
            cbm_pkg::KIND_ADD:
            begin
                slot_hit = add_ok && s_valid && s_type == type_reg &&
                    ((type_reg == cbm_pkg::TYPE_CONTACT) ? (s_cid == cid_reg) : exact_eq);
            end
            cbm_pkg::KIND_CHECK:
            begin
                if (s_type == cbm_pkg::TYPE_CONTACT) begin
                    slot_hit = s_valid && (s_cid == cid_reg);
                end else if (s_type == cbm_pkg::TYPE_NUMBER) begin
                    slot_hit = s_valid && num_hit;
                end else begin
                    slot_hit = s_valid && pfx_hit;
                end
            end
            cbm_pkg::KIND_FIND_ID:
            begin
                slot_hit = (cid_reg != '0) && s_valid &&
                    s_type == cbm_pkg::TYPE_CONTACT && s_cid == cid_reg;
            end
            cbm_pkg::KIND_FIND_NUM:
            begin
                slot_hit = (len_reg != '0) && s_valid && exact_eq;
            end
            default:
            begin
                slot_hit = 1'b0;
            end
        endcase
        stat.hit = slot_hit;
        stat.scan_last = (idx_reg == SW'(cbm_pkg::TableEntries - 1));
    end

    // Capture item and run the scan
    always_ff @(posedge clk)
    begin
        if (cmd.load) begin
            kind_reg <= kind;
            type_reg <= entry_type;
            cid_reg  <= contact_id;
            dig_reg  <= in_dig;
            len_reg  <= in_len;
            slot_reg <= entry_slot;
            if (in_len != '0 && in_dig[63:60] == 4'd1) begin
                cdig_reg <= {in_dig[59:0], 4'd0};
                clen_reg <= in_len - CW'(1);
            end else begin
                cdig_reg <= in_dig;
                clen_reg <= in_len;
            end
        end
        if (cmd.scan_rst) begin
            idx_reg <= '0;
            hit_reg <= 1'b0;
            free_reg <= 1'b0;
        end else if (cmd.scan_step) begin
            idx_reg <= idx_reg + SW'(1);
            if (slot_hit) begin
                hit_reg <= 1'b1;
                hit_idx_reg <= idx_reg;
            end
            if (!s_valid && !free_reg) begin
                free_reg <= 1'b1;
                free_idx_reg <= idx_reg;
            end
        end
    end

    // Table entry write on a successful add
    logic do_add;
    logic do_del;
    assign do_add = cmd.commit && kind_reg == cbm_pkg::KIND_ADD && add_ok && !hit_reg && free_reg;
    assign do_del = cmd.commit && kind_reg == cbm_pkg::KIND_DELETE && valid_reg[slot_reg[SW-1:0]];

    always_ff @(posedge clk)
    begin
        if (do_add) begin
            type_mem[free_idx_reg]    <= type_reg;
            contact_mem[free_idx_reg] <= cid_reg;
            digits_mem[free_idx_reg]  <= dig_reg;
            length_mem[free_idx_reg]  <= len_reg;
        end
    end

    // Build result, update valid bits and version
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            valid_reg <= '0;
            ver_reg <= '0;
        end else begin
            if (do_add) begin
                valid_reg[free_idx_reg] <= 1'b1;
            end
            if (do_del) begin
                valid_reg[slot_reg[SW-1:0]] <= 1'b0;
            end
            if (do_add || do_del) begin
                ver_reg <= ver_reg + 4'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.commit) begin
            blocked_reg <= 1'b0;
            found_reg <= '0;
            case (kind_reg)
                cbm_pkg::KIND_ADD:
                begin
                    if (!add_ok) begin
                        status_reg <= cbm_pkg::ST_INVALID;
                    end else if (hit_reg) begin
                        status_reg <= cbm_pkg::ST_DUPLICATE;
                    end else if (!free_reg) begin
                        status_reg <= cbm_pkg::ST_FULL;
                    end else begin
                        status_reg <= cbm_pkg::ST_OK;
                        found_reg <= 5'(free_idx_reg);
                    end
                end
                cbm_pkg::KIND_DELETE:
                begin
                    status_reg <= do_del ? cbm_pkg::ST_OK : cbm_pkg::ST_NOT_FOUND;
                end
                cbm_pkg::KIND_CHECK:
                begin
                    status_reg <= cbm_pkg::ST_OK;
                    blocked_reg <= hit_reg;
                    found_reg <= hit_reg ? 5'(hit_idx_reg) : 5'd0;
                end
                cbm_pkg::KIND_FIND_ID, cbm_pkg::KIND_FIND_NUM:
                begin
                    if ((kind_reg == cbm_pkg::KIND_FIND_ID) ? (cid_reg == '0) : (len_reg == '0)) begin
                        status_reg <= cbm_pkg::ST_INVALID;
                    end else if (hit_reg) begin
                        status_reg <= cbm_pkg::ST_OK;
                        found_reg <= 5'(hit_idx_reg);
                    end else begin
                        status_reg <= cbm_pkg::ST_NOT_FOUND;
                    end
                end
                default:
                begin
                    status_reg <= cbm_pkg::ST_INVALID;
                end
            endcase
        end
    end

    assign status = status_reg;
    assign blocked = blocked_reg;
    assign found_slot = found_reg;
    assign list_version = ver_reg;

    a_add_del: assert property (@(posedge clk) disable iff (!rst_n) !(do_add && do_del))
        else $error("add and delete together");
    a_ver_step: assert property (@(posedge clk) disable iff (!rst_n)
        (do_add || do_del) |=> list_version == $past(list_version) + 4'd1)
        else $error("version not raised");
    a_add_sets: assert property (@(posedge clk) disable iff (!rst_n)
        do_add |=> valid_reg[$past(free_idx_reg)]) else $error("added slot not valid");

endmodule
